[rtl/core/pic_pkg.sv]
// Shared types and constants for the point-in-convex-polygon block.
// Used by every module under rtl/core; depends on nothing.
package pic_pkg;

  localparam int COORD_WIDTH = 24;
  localparam int DIFF_WIDTH  = COORD_WIDTH + 1;
  localparam int PROD_WIDTH  = 2 * DIFF_WIDTH;
  localparam int SUM_WIDTH   = PROD_WIDTH + 1;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic signed [DIFF_WIDTH-1:0]  diff_t;
  typedef logic signed [PROD_WIDTH-1:0]  prod_t;
  typedef logic signed [SUM_WIDTH-1:0]   sum_t;

  // One classified vertex: the operand differences of its edge and of the
  // closing edge, plus the flags the back end needs.
  typedef struct packed {
    logic  empty;
    logic  first;
    logic  last;
    logic  norm_neg;
    logic  norm_zero;
    diff_t e_a;
    diff_t e_b;
    diff_t e_c;
    diff_t e_d;
    diff_t c_a;
    diff_t c_b;
    diff_t c_c;
    diff_t c_d;
  } entry_t;

endpackage

[rtl/core/point_in_convex_polygon.sv]
// Point-in-convex-polygon test, one vertex transaction per cycle sustained while in_stall is low.
// A result appears on out_valid once the closing vertex (or empty-polygon)
// transaction is accepted and has passed the queue write, then the multiply
// stage, then sign/verdict into the output register.
// Reset clears the queue, pipeline valids and polygon state; verdict reads inside.
module point_in_convex_polygon (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  pic_pkg::coord_t normal_x,
  input  pic_pkg::coord_t normal_y,
  input  pic_pkg::coord_t normal_z,
  input  pic_pkg::coord_t point_x,
  input  pic_pkg::coord_t point_y,
  input  pic_pkg::coord_t point_z,
  input  pic_pkg::coord_t vertex_x,
  input  pic_pkg::coord_t vertex_y,
  input  pic_pkg::coord_t vertex_z,
  input  logic            first_vertex,
  input  logic            last_vertex,
  input  logic            no_vertices,
  output logic            out_valid,
  input  logic            out_stall,
  output logic            inside_res
);

  logic            push, pop, full, avail;
  pic_pkg::entry_t push_data, pop_data;

  pic_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .normal_x     (normal_x),
    .normal_y     (normal_y),
    .normal_z     (normal_z),
    .point_x      (point_x),
    .point_y      (point_y),
    .point_z      (point_z),
    .vertex_x     (vertex_x),
    .vertex_y     (vertex_y),
    .vertex_z     (vertex_z),
    .first_vertex (first_vertex),
    .last_vertex  (last_vertex),
    .no_vertices  (no_vertices),
    .queue_full   (full),
    .push         (push),
    .push_data    (push_data)
  );

  pic_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .avail     (avail),
    .pop_data  (pop_data)
  );

  pic_back u_back (
    .clk        (clk),
    .rst        (rst),
    .avail      (avail),
    .pop_data   (pop_data),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .inside_res (inside_res)
  );

endmodule

[rtl/core/pic_front.sv]
// Front end: accepts vertex transactions, tracks polygon state, projects
// coordinates and forms the edge operand differences. Uses pic_pkg.
module pic_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  pic_pkg::coord_t    normal_x,
  input  pic_pkg::coord_t    normal_y,
  input  pic_pkg::coord_t    normal_z,
  input  pic_pkg::coord_t    point_x,
  input  pic_pkg::coord_t    point_y,
  input  pic_pkg::coord_t    point_z,
  input  pic_pkg::coord_t    vertex_x,
  input  pic_pkg::coord_t    vertex_y,
  input  pic_pkg::coord_t    vertex_z,
  input  logic               first_vertex,
  input  logic               last_vertex,
  input  logic               no_vertices,
  input  logic               queue_full,
  output logic               push,
  output pic_pkg::entry_t    push_data
);

  typedef struct packed {
    pic_pkg::coord_t u;
    pic_pkg::coord_t v;
  } uv_t;

  function automatic uv_t project(logic [1:0] axis, pic_pkg::coord_t x,
                                  pic_pkg::coord_t y, pic_pkg::coord_t z);
    uv_t r;
    case (axis)
      pic_pkg::AXIS_X: begin
        r.u = y;
        r.v = z;
      end
      pic_pkg::AXIS_Y: begin
        r.u = z;
        r.v = x;
      end
      default: begin
        r.u = x;
        r.v = y;
      end
    endcase
    return r;
  endfunction

  function automatic logic [pic_pkg::COORD_WIDTH:0] mag(pic_pkg::coord_t a);
    logic signed [pic_pkg::COORD_WIDTH:0] ext;
    ext = {a[pic_pkg::COORD_WIDTH-1], a};
    return ext[pic_pkg::COORD_WIDTH] ? -ext : ext;
  endfunction

  function automatic pic_pkg::diff_t sub(pic_pkg::coord_t a, pic_pkg::coord_t b);
    return {a[pic_pkg::COORD_WIDTH-1], a} - {b[pic_pkg::COORD_WIDTH-1], b};
  endfunction

  logic [1:0]      dominant_axis;
  pic_pkg::coord_t dominant_normal;
  pic_pkg::coord_t target_u, target_v;
  pic_pkg::coord_t first_u, first_v;
  pic_pkg::coord_t previous_u, previous_v;

  logic [pic_pkg::COORD_WIDTH:0] mag_x, mag_y, mag_z, mag_dom;
  logic [1:0]      axis_new, axis_use;
  pic_pkg::coord_t norm_new, norm_use;
  uv_t             cur, tgt_new;
  pic_pkg::coord_t tu_use, tv_use, fu_use, fv_use;
  logic            accept;

  assign in_stall = queue_full;
  assign accept   = in_valid && !queue_full;
  assign push     = accept;

  always_comb begin
    mag_x = mag(normal_x);
    mag_y = mag(normal_y);
    mag_z = mag(normal_z);
    // y must strictly beat x, z must strictly beat the winner
    if (mag_y > mag_x) begin
      axis_new = pic_pkg::AXIS_Y;
      norm_new = normal_y;
      mag_dom  = mag_y;
    end else begin
      axis_new = pic_pkg::AXIS_X;
      norm_new = normal_x;
      mag_dom  = mag_x;
    end
    if (mag_z > mag_dom) begin
      axis_new = pic_pkg::AXIS_Z;
      norm_new = normal_z;
    end

    axis_use = first_vertex ? axis_new : dominant_axis;
    norm_use = first_vertex ? norm_new : dominant_normal;
    cur      = project(axis_use, vertex_x, vertex_y, vertex_z);
    tgt_new  = project(axis_new, point_x, point_y, point_z);
    tu_use   = first_vertex ? tgt_new.u : target_u;
    tv_use   = first_vertex ? tgt_new.v : target_v;
    fu_use   = first_vertex ? cur.u : first_u;
    fv_use   = first_vertex ? cur.v : first_v;

    push_data.empty     = no_vertices;
    push_data.first     = first_vertex;
    push_data.last      = last_vertex;
    push_data.norm_neg  = norm_use[pic_pkg::COORD_WIDTH-1];
    push_data.norm_zero = (norm_use == '0);
    // edge previous -> current
    push_data.e_a = sub(previous_v, cur.v);
    push_data.e_b = sub(tu_use, previous_u);
    push_data.e_c = sub(cur.u, previous_u);
    push_data.e_d = sub(tv_use, previous_v);
    // closing edge current -> first
    push_data.c_a = sub(cur.v, fv_use);
    push_data.c_b = sub(tu_use, cur.u);
    push_data.c_c = sub(fu_use, cur.u);
    push_data.c_d = sub(tv_use, cur.v);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dominant_axis   <= pic_pkg::AXIS_X;
      dominant_normal <= '0;
      target_u        <= '0;
      target_v        <= '0;
      first_u         <= '0;
      first_v         <= '0;
      previous_u      <= '0;
      previous_v      <= '0;
    end else if (accept && !no_vertices) begin
      if (first_vertex) begin
        dominant_axis   <= axis_new;
        dominant_normal <= norm_new;
        target_u        <= tgt_new.u;
        target_v        <= tgt_new.v;
        first_u         <= cur.u;
        first_v         <= cur.v;
      end
      previous_u <= cur.u;
      previous_v <= cur.v;
    end
  end

endmodule

[rtl/core/pic_queue.sv]
// Short queue of classified vertices between front and back end.
// Register-file storage with count-based full flag. Uses pic_pkg.
module pic_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  pic_pkg::entry_t push_data,
  output logic            full,
  input  logic            pop,
  output logic            avail,
  output pic_pkg::entry_t pop_data
);

  localparam logic [pic_pkg::QUEUE_AW-1:0] LastSlot =
    pic_pkg::QUEUE_AW'(pic_pkg::QUEUE_DEPTH - 1);
  localparam logic [pic_pkg::QUEUE_AW:0] FullCount =
    (pic_pkg::QUEUE_AW + 1)'(pic_pkg::QUEUE_DEPTH);

  pic_pkg::entry_t slots [pic_pkg::QUEUE_DEPTH];
  logic [pic_pkg::QUEUE_AW-1:0] wr_ptr, rd_ptr;
  logic [pic_pkg::QUEUE_AW:0]   count;

  assign full     = (count == FullCount);
  assign avail    = (count != '0);
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LastSlot) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LastSlot) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= FullCount)
    else $error("queue count above depth");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !full)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> avail)
    else $error("pop from empty queue");

endmodule

[rtl/core/pic_back.sv]
// Back end: multiplies the edge operands, signs the cross terms, folds the
// per-polygon verdict and holds the result register. Uses pic_pkg.
module pic_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            avail,
  input  pic_pkg::entry_t pop_data,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_stall,
  output logic            inside_res
);

  logic            s1_valid;
  logic            s1_empty, s1_first, s1_last, s1_norm_neg, s1_norm_zero;
  pic_pkg::prod_t  p_e1, p_e2, p_c1, p_c2;
  logic            inside_so_far;

  pic_pkg::sum_t   side_e, side_c;
  logic            reg_out, close_out, inside_new, emit, res;
  logic            out_free, s1_adv, s1_load;

  always_comb begin
    side_e = pic_pkg::sum_t'(p_e1) + pic_pkg::sum_t'(p_e2);
    side_c = pic_pkg::sum_t'(p_c1) + pic_pkg::sum_t'(p_c2);
    // zero side or zero normal never puts the point outside
    reg_out = !s1_first && !s1_norm_zero && (side_e != '0) &&
              (side_e[pic_pkg::SUM_WIDTH-1] != s1_norm_neg);
    close_out = s1_last && !s1_norm_zero && (side_c != '0) &&
                (side_c[pic_pkg::SUM_WIDTH-1] != s1_norm_neg);
    inside_new = (s1_first || inside_so_far) && !reg_out;
    emit       = s1_empty || s1_last;
    res        = s1_empty || (inside_new && !close_out);
    out_free   = !out_valid || !out_stall;
    s1_adv     = s1_valid && (!emit || out_free);
    s1_load    = avail && (!s1_valid || s1_adv);
  end

  assign pop = s1_load;

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_empty     <= pop_data.empty;
      s1_first     <= pop_data.first;
      s1_last      <= pop_data.last;
      s1_norm_neg  <= pop_data.norm_neg;
      s1_norm_zero <= pop_data.norm_zero;
      p_e1 <= pop_data.e_a * pop_data.e_b;
      p_e2 <= pop_data.e_c * pop_data.e_d;
      p_c1 <= pop_data.c_a * pop_data.c_b;
      p_c2 <= pop_data.c_c * pop_data.c_d;
    end
    if (s1_adv && emit) begin
      inside_res <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid      <= 1'b0;
      out_valid     <= 1'b0;
      inside_so_far <= 1'b1;
    end else begin
      s1_valid  <= s1_load || (s1_valid && !s1_adv);
      out_valid <= (s1_adv && emit) || (out_valid && out_stall);
      if (s1_adv) begin
        inside_so_far <= emit ? 1'b1 : inside_new;
      end
    end
  end

  a_empty_inside: assert property (@(posedge clk) disable iff (rst)
    (s1_adv && s1_empty) |=> (out_valid && inside_res))
    else $error("empty polygon not reported inside");

  a_verdict_rearm: assert property (@(posedge clk) disable iff (rst)
    (s1_adv && emit) |=> inside_so_far)
    else $error("verdict not rearmed after result");

  a_no_clobber: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |-> !(s1_adv && emit))
    else $error("result overwritten while stalled");

endmodule

[tb/testbench.sv]
// Self-checking testbench for point_in_convex_polygon: streams vertex transactions,
// predicts each inside/outside verdict and compares it with what the block returns.
// Depends on pic_pkg and the point_in_convex_polygon RTL only.
module testbench;
  import pic_pkg::*;

  localparam int CYCLE_LIMIT  = 200_000;
  localparam int RANDOM_ITEMS = 1250;
  localparam int IDLE_PERCENT = 29;

  typedef struct {
    coord_t nx, ny, nz;
    coord_t px, py, pz;
    coord_t vx, vy, vz;
    bit     first, last, empty;
  } vertex_item_t;

  logic   clk = 1'b0;
  logic   rst = 1'b1;
  logic   in_valid = 1'b0;
  logic   in_stall;
  coord_t normal_x = '0, normal_y = '0, normal_z = '0;
  coord_t point_x = '0, point_y = '0, point_z = '0;
  coord_t vertex_x = '0, vertex_y = '0, vertex_z = '0;
  logic   first_vertex = 1'b0, last_vertex = 1'b0, no_vertices = 1'b0;
  logic   out_valid;
  logic   out_stall = 1'b0;
  logic   inside_res;

  point_in_convex_polygon dut (.*);

  always #2 clk = ~clk;

  // Polygon state as the block should hold it
  logic [1:0] dom_axis = AXIS_X;
  longint     dom_normal = 0;
  longint     tgt_u = 0, tgt_v = 0;
  longint     first_u = 0, first_v = 0;
  longint     prev_u = 0, prev_v = 0;
  bit         still_inside = 1'b1;
  bit         inside_expected_q[$];

  bit     calm = 1'b0;
  coord_t sel_normal[3];
  coord_t sel_point[3];
  int     errors = 0;
  int     items_sent = 0;
  int     polygon_items = 0;
  int     polygons_sent = 0;
  int     verdicts_seen = 0;
  int     inside_seen = 0;
  int     cycles = 0;
  bit     verdict_expected;

  function automatic longint mag_of(input longint x);
    return (x < 0) ? -x : x;
  endfunction

  function automatic void project_axes(input logic [1:0] axis, input coord_t x, y, z,
                                       output longint u, output longint v);
    case (axis)
      AXIS_X:  begin u = y; v = z; end
      AXIS_Y:  begin u = z; v = x; end
      default: begin u = x; v = y; end
    endcase
  endfunction

  // True when edge P->C leaves the target strictly on the wrong side
  function automatic bit edge_excludes(input longint pu, pv, cu, cv);
    longint side;
    side = (pv - cv) * (tgt_u - pu) + (cu - pu) * (tgt_v - pv);
    if (side == 0 || dom_normal == 0) return 1'b0;
    return (side < 0) != (dom_normal < 0);
  endfunction

  function automatic void track_vertex(input vertex_item_t it);
    longint     cu, cv;
    longint     n[3];
    logic [1:0] ax;
    if (it.empty) begin
      still_inside = 1'b1;
      inside_expected_q.push_back(1'b1);
      return;
    end
    if (it.first) begin
      n[0] = it.nx;
      n[1] = it.ny;
      n[2] = it.nz;
      ax = (mag_of(n[1]) > mag_of(n[0])) ? AXIS_Y : AXIS_X;
      if (mag_of(n[2]) > mag_of(n[ax])) ax = AXIS_Z;
      dom_axis = ax;
      dom_normal = n[ax];
      project_axes(ax, it.px, it.py, it.pz, tgt_u, tgt_v);
      project_axes(ax, it.vx, it.vy, it.vz, cu, cv);
      first_u = cu;
      first_v = cv;
      still_inside = 1'b1;
    end else begin
      project_axes(dom_axis, it.vx, it.vy, it.vz, cu, cv);
      if (edge_excludes(prev_u, prev_v, cu, cv)) still_inside = 1'b0;
    end
    prev_u = cu;
    prev_v = cv;
    if (it.last) begin
      inside_expected_q.push_back(still_inside && !edge_excludes(cu, cv, first_u, first_v));
      still_inside = 1'b1;
    end
  endfunction

  function automatic vertex_item_t random_item();
    vertex_item_t it;
    it.nx = coord_t'($urandom);
    it.ny = coord_t'($urandom);
    it.nz = coord_t'($urandom);
    it.px = coord_t'($urandom);
    it.py = coord_t'($urandom);
    it.pz = coord_t'($urandom);
    it.vx = coord_t'($urandom);
    it.vy = coord_t'($urandom);
    it.vz = coord_t'($urandom);
    it.first = 1'b0;
    it.last = 1'b0;
    it.empty = 1'b0;
    return it;
  endfunction

  function automatic vertex_item_t make_vertex(input coord_t x, y, z, input bit first, last);
    vertex_item_t it;
    it.nx = sel_normal[0];
    it.ny = sel_normal[1];
    it.nz = sel_normal[2];
    it.px = sel_point[0];
    it.py = sel_point[1];
    it.pz = sel_point[2];
    it.vx = x;
    it.vy = y;
    it.vz = z;
    it.first = first;
    it.last = last;
    it.empty = 1'b0;
    return it;
  endfunction

  task automatic send_vertex(input vertex_item_t it);
    while (!calm && $urandom_range(0, 99) < IDLE_PERCENT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    normal_x <= it.nx;
    normal_y <= it.ny;
    normal_z <= it.nz;
    point_x <= it.px;
    point_y <= it.py;
    point_z <= it.pz;
    vertex_x <= it.vx;
    vertex_y <= it.vy;
    vertex_z <= it.vz;
    first_vertex <= it.first;
    last_vertex <= it.last;
    no_vertices <= it.empty;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    track_vertex(it);
    items_sent++;
  endtask

  task automatic set_view(input coord_t nx, ny, nz, px, py, pz);
    sel_normal = '{nx, ny, nz};
    sel_point = '{px, py, pz};
  endtask

  // Vertices before any first vertex run on the reset state: zero normal, inside
  task automatic test_missing_first();
    set_view(24'sd4096, 24'sd0, 24'sd0, 24'sd999, -24'sd999, 24'sd5);
    send_vertex(make_vertex(24'sd100, 24'sd200, 24'sd300, 1'b0, 1'b0));
    send_vertex(make_vertex(-24'sd5, 24'sd7, 24'sd9, 1'b0, 1'b1));
  endtask

  task automatic test_empty_and_single();
    vertex_item_t it;
    it = random_item();
    it.empty = 1'b1;
    it.first = 1'b1;
    it.last = 1'b1;
    send_vertex(it);
    set_view(24'sd4096, -24'sd8192, 24'sd100, 24'sd77, 24'sd88, -24'sd99);
    send_vertex(make_vertex(24'sd10, 24'sd20, 24'sd30, 1'b1, 1'b1));
  endtask

  // Equal magnitudes keep the earlier axis: x over y, then y over z
  task automatic test_axis_ties();
    set_view(24'sd20480, 24'sd20480, 24'sd4096, 24'sd0, -24'sd4096, -24'sd4096);
    send_vertex(make_vertex(24'sd0, 24'sd0, 24'sd0, 1'b1, 1'b0));
    send_vertex(make_vertex(24'sd0, 24'sd4096, 24'sd0, 1'b0, 1'b0));
    send_vertex(make_vertex(24'sd0, 24'sd0, 24'sd4096, 1'b0, 1'b1));
    set_view(-24'sd12288, 24'sd20480, 24'sd20480, -24'sd4096, 24'sd0, -24'sd4096);
    send_vertex(make_vertex(24'sd0, 24'sd0, 24'sd0, 1'b1, 1'b0));
    send_vertex(make_vertex(24'sd0, 24'sd0, 24'sd4096, 1'b0, 1'b0));
    send_vertex(make_vertex(24'sd4096, 24'sd0, 24'sd0, 1'b0, 1'b1));
  endtask

  // Full-scale coordinates drive the widest edge products
  task automatic test_extremes();
    set_view(-24'sd8388608, 24'sd8388607, 24'sd0, -24'sd8388608, 24'sd8388607, 24'sd8388607);
    send_vertex(make_vertex(24'sd8388607, 24'sd8388607, -24'sd8388608, 1'b1, 1'b0));
    send_vertex(make_vertex(-24'sd8388608, -24'sd8388608, -24'sd8388608, 1'b0, 1'b0));
    send_vertex(make_vertex(24'sd0, 24'sd0, 24'sd8388607, 1'b0, 1'b1));
    set_view(24'sd0, 24'sd0, -24'sd8388608, 24'sd8388607, -24'sd8388608, 24'sd0);
    send_vertex(make_vertex(-24'sd8388608, 24'sd8388607, 24'sd8388607, 1'b1, 1'b0));
    send_vertex(make_vertex(24'sd8388607, 24'sd8388607, -24'sd8388608, 1'b0, 1'b0));
    send_vertex(make_vertex(24'sd8388607, -24'sd8388608, 24'sd0, 1'b0, 1'b1));
  endtask

  // Target exactly on an edge gives a zero term, which counts as inside
  task automatic test_point_on_edge();
    set_view(24'sd0, 24'sd0, 24'sd4096, 24'sd8, 24'sd4, 24'sd1234);
    send_vertex(make_vertex(24'sd0, 24'sd0, 24'sd0, 1'b1, 1'b0));
    send_vertex(make_vertex(24'sd8, 24'sd0, 24'sd0, 1'b0, 1'b0));
    send_vertex(make_vertex(24'sd8, 24'sd8, 24'sd0, 1'b0, 1'b0));
    send_vertex(make_vertex(24'sd0, 24'sd8, 24'sd0, 1'b0, 1'b1));
  endtask

  // An empty polygon drops the one in progress; later vertices reuse the held state
  task automatic test_abandoned_polygon();
    vertex_item_t it;
    set_view(24'sd0, 24'sd0, -24'sd4096, 24'sd50, 24'sd50, 24'sd0);
    send_vertex(make_vertex(24'sd0, 24'sd0, 24'sd0, 1'b1, 1'b0));
    it = random_item();
    it.empty = 1'b1;
    send_vertex(it);
    send_vertex(make_vertex(24'sd100, 24'sd0, 24'sd0, 1'b0, 1'b1));
  endtask

  task automatic send_noise(input int count);
    vertex_item_t it;
    repeat (count) begin
      it = random_item();
      it.first = ($urandom_range(0, 99) < 30);
      it.last = ($urandom_range(0, 99) < 30);
      it.empty = ($urandom_range(0, 99) < 6);
      send_vertex(it);
    end
  endtask

  // Convex octagon (or a subset of its corners) in the plane of a random axis
  task automatic send_random_polygon();
    vertex_item_t it;
    logic [1:0]   ax;
    int           iu, iv, s, k, idx;
    bit           reversed, drop_last;
    logic [7:0]   mask;
    longint       a, b, ctr_u, ctr_v, tu, tv, mg, span;
    longint       ou[8], ov[8];
    coord_t       nrm[3], pt[3], vtx[3];
    int           picks[$];
    case ($urandom_range(0, 2))
      0:       ax = AXIS_X;
      1:       ax = AXIS_Y;
      default: ax = AXIS_Z;
    endcase
    iu = (int'(ax) + 1) % 3;
    iv = (int'(ax) + 2) % 3;
    case ($urandom_range(0, 3))
      0:       span = 16;
      1:       span = 4096;
      2:       span = 1 << 16;
      default: span = 1 << 21;
    endcase
    a = $urandom_range(1, span);
    b = $urandom_range(1, span);
    ctr_u = longint'($urandom_range(0, 1 << 22)) - (1 << 21);
    ctr_v = longint'($urandom_range(0, 1 << 22)) - (1 << 21);
    ou = '{a, a, a / 2, -(a / 2), -a, -a, -(a / 2), a / 2};
    ov = '{-(b / 2), b / 2, b, b, b / 2, -(b / 2), -b, -b};
    if ($urandom_range(0, 99) < 8) begin
      mask = 8'd1 << $urandom_range(0, 7);
      if ($urandom_range(0, 1)) mask |= 8'd1 << $urandom_range(0, 7);
    end else begin
      mask = 8'($urandom);
      if ($countones(mask) < 3) mask = 8'hFF;
    end
    s = $urandom_range(0, 7);
    reversed = $urandom_range(0, 1);
    for (k = 0; k < 8; k++) begin
      idx = reversed ? (s - k + 8) % 8 : (s + k) % 8;
      if (mask[idx]) picks.push_back(idx);
    end
    case ($urandom_range(0, 3))
      0: begin
        tu = ctr_u;
        tv = ctr_v;
      end
      3: begin
        idx = picks[$urandom_range(0, picks.size() - 1)];
        tu = ctr_u + ou[idx];
        tv = ctr_v + ov[idx];
      end
      default: begin
        tu = ctr_u + longint'($urandom_range(0, 4 * a)) - 2 * a;
        tv = ctr_v + longint'($urandom_range(0, 4 * b)) - 2 * b;
      end
    endcase
    // Dominant component strictly largest; occasionally zero or full negative scale
    mg = longint'($urandom_range(1, 8388607)) >> $urandom_range(0, 22);
    if (mg == 0) mg = 1;
    if ($urandom_range(0, 99) < 5) mg = 0;
    nrm[ax] = coord_t'($urandom_range(0, 1) ? -mg : mg);
    if ($urandom_range(0, 29) == 0) begin
      mg = 8388608;
      nrm[ax] = coord_t'(-mg);
    end
    nrm[iu] = (mg > 1) ? coord_t'(longint'($urandom_range(0, 2 * (mg - 1))) - (mg - 1)) : '0;
    nrm[iv] = (mg > 1) ? coord_t'(longint'($urandom_range(0, 2 * (mg - 1))) - (mg - 1)) : '0;
    pt[iu] = coord_t'(tu);
    pt[iv] = coord_t'(tv);
    pt[ax] = coord_t'($urandom);
    drop_last = ($urandom_range(0, 99) < 6);
    for (k = 0; k < picks.size(); k++) begin
      it = random_item();
      if (k == 0) begin
        it.nx = nrm[0];
        it.ny = nrm[1];
        it.nz = nrm[2];
        it.px = pt[0];
        it.py = pt[1];
        it.pz = pt[2];
      end
      vtx[iu] = coord_t'(ctr_u + ou[picks[k]]);
      vtx[iv] = coord_t'(ctr_v + ov[picks[k]]);
      vtx[ax] = coord_t'($urandom);
      it.vx = vtx[0];
      it.vy = vtx[1];
      it.vz = vtx[2];
      it.first = (k == 0);
      it.last = (k == picks.size() - 1) && !drop_last;
      send_vertex(it);
      polygon_items++;
    end
    polygons_sent++;
  endtask

  task automatic test_random_traffic();
    int start;
    start = items_sent;
    while (items_sent - start < RANDOM_ITEMS) begin
      // hold both sides busy through one stretch in the middle
      calm <= (items_sent - start >= 500) && (items_sent - start < 700);
      if ($urandom_range(0, 99) < 82) send_random_polygon();
      else send_noise($urandom_range(1, 4));
    end
    calm <= 1'b0;
  endtask

  always @(posedge clk) begin
    out_stall <= !calm && ($urandom_range(0, 99) < IDLE_PERCENT);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      verdicts_seen++;
      if (inside_res) inside_seen++;
      if (inside_expected_q.size() == 0) begin
        $error("inside_res: expected no transaction, actual %0b", inside_res);
        errors++;
      end else begin
        verdict_expected = inside_expected_q.pop_front();
        if (inside_res !== verdict_expected) begin
          $error("inside_res: expected %0b, actual %0b", verdict_expected, inside_res);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timed out with %0d verdicts outstanding", inside_expected_q.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_missing_first();
    test_empty_and_single();
    test_axis_ties();
    test_extremes();
    test_point_on_edge();
    test_abandoned_polygon();
    test_random_traffic();
    in_valid <= 1'b0;
    while (inside_expected_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    $display("Sent %0d vertex transactions, %0d of them in random polygons (%0d polygons).",
             items_sent, polygon_items, polygons_sent);
    $display("Checked %0d verdicts: %0d inside, %0d outside.",
             verdicts_seen, inside_seen, verdicts_seen - inside_seen);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
